// ===== hw/rtl/twc_pkg.sv =====
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants of the thresholded window centroid
// Holds the fixed field widths, the register map and the register reset values.
// ----------------------------------------------------------------------------
package twc_pkg;

	// Fixed field and state widths.
	localparam int PIX_W   = 8;
	localparam int FRAC_W  = 8;
	localparam int SUM_W   = 24;
	localparam int CNT_W   = 12;
	localparam int STEP_W  = 6;
	localparam int DIM_W   = 13;
	localparam int CFG_W   = 13;
	localparam int INDEX_W = 2;

	// Register indexes of the configuration port.
	typedef enum logic [INDEX_W-1:0] {
		REG_BRIGHT_THRESHOLD = 2'd0,
		REG_WINDOW_SIZE      = 2'd1,
		REG_IMAGE_WIDTH      = 2'd2,
		REG_IMAGE_HEIGHT     = 2'd3
	} reg_index_t;

	// Register reset values.
	localparam logic [PIX_W-1:0]  THRESHOLD_RST = 8'd250;
	localparam logic [STEP_W-1:0] WINDOW_RST    = 6'd5;
	localparam logic [DIM_W-1:0]  WIDTH_RST     = 13'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RST    = 13'd480;

	// Current register contents as seen by the front part.
	typedef struct packed {
		logic [PIX_W-1:0]  bright_threshold;
		logic [STEP_W-1:0] window_size;
		logic [DIM_W-1:0]  image_width;
		logic [DIM_W-1:0]  image_height;
	} cfg_t;

endpackage

// ===== hw/rtl/twc_front.sv =====
// ----------------------------------------------------------------------------
// twc_front: pixel accumulator
// Takes one window pixel per cycle while in_accept is high, sums the positions of bright pixels and,
// on the last pixel, hands a finished window job to the queue.
// ----------------------------------------------------------------------------
module twc_front #(
	parameter int MAX_WINDOW = 63,
	parameter int COORD_BITS = 12,
	localparam int JOB_W = 1 + twc_pkg::CNT_W + 2 * twc_pkg::SUM_W + 2 * COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  twc_pkg::cfg_t                cfg,
	input  logic                         in_accept,
	input  logic [twc_pkg::PIX_W-1:0]    in_pixel,
	input  logic [COORD_BITS-1:0]        in_center_x,
	input  logic [COORD_BITS-1:0]        in_center_y,
	input  logic                         in_last,
	output logic                         job_push,
	output logic [JOB_W-1:0]             job_data
);

	localparam int SUM_W  = twc_pkg::SUM_W;
	localparam int CNT_W  = twc_pkg::CNT_W;
	localparam int STEP_W = twc_pkg::STEP_W;
	localparam int CMP_W  = (COORD_BITS > twc_pkg::DIM_W) ? COORD_BITS : twc_pkg::DIM_W;

	logic [SUM_W-1:0]          col_sum_q, row_sum_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [STEP_W-1:0]         col_step_q, row_step_q;

	logic [STEP_W-1:0]         side;
	logic [STEP_W-2:0]         half;
	logic signed [COORD_BITS:0] fx, fy;
	logic [SUM_W-1:0]          fx_ext, fy_ext;
	logic [SUM_W-1:0]          col_sum_nx, row_sum_nx;
	logic [CNT_W-1:0]          cnt_nx;
	logic                      bright;
	logic                      row_wrap;
	logic                      outside;

	// Effective window side, half side and window start of this pixel.
	always_comb begin
		if (cfg.window_size == '0) begin
			side = STEP_W'(1);
		end else if (cfg.window_size > STEP_W'(MAX_WINDOW)) begin
			side = STEP_W'(MAX_WINDOW);
		end else begin
			side = cfg.window_size;
		end
		half = (STEP_W - 1)'((side - STEP_W'(1)) >> 1);
		fx = (COORD_BITS + 1)'(in_center_x) - (COORD_BITS + 1)'(half);
		fy = (COORD_BITS + 1)'(in_center_y) - (COORD_BITS + 1)'(half);
		fx_ext = {{(SUM_W - COORD_BITS - 1){fx[COORD_BITS]}}, fx};
		fy_ext = {{(SUM_W - COORD_BITS - 1){fy[COORD_BITS]}}, fy};
	end

	// Running sums with this pixel folded in.
	always_comb begin
		bright = in_pixel > cfg.bright_threshold;
		col_sum_nx = col_sum_q;
		row_sum_nx = row_sum_q;
		cnt_nx = cnt_q;
		if (bright) begin
			col_sum_nx = col_sum_q + fx_ext + SUM_W'(col_step_q);
			row_sum_nx = row_sum_q + fy_ext + SUM_W'(row_step_q);
			cnt_nx = cnt_q + CNT_W'(1);
		end
		row_wrap = ({1'b0, col_step_q} + (STEP_W + 1)'(1)) >= {1'b0, side};
	end

	// Start check against the image bounds.
	always_comb begin
		outside = fx[COORD_BITS] || fy[COORD_BITS]
			|| (CMP_W'(fx[COORD_BITS-1:0]) > CMP_W'(cfg.image_width))
			|| (CMP_W'(fy[COORD_BITS-1:0]) > CMP_W'(cfg.image_height));
	end

	assign job_push = in_accept && in_last;
	assign job_data = {!outside && (cnt_nx != '0), cnt_nx, col_sum_nx, row_sum_nx,
		in_center_x, in_center_y};

	// Accumulators and window position; cleared when a window closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_sum_q  <= '0;
			row_sum_q  <= '0;
			cnt_q      <= '0;
			col_step_q <= '0;
			row_step_q <= '0;
		end else if (in_accept) begin
			if (in_last) begin
				col_sum_q  <= '0;
				row_sum_q  <= '0;
				cnt_q      <= '0;
				col_step_q <= '0;
				row_step_q <= '0;
			end else begin
				col_sum_q <= col_sum_nx;
				row_sum_q <= row_sum_nx;
				cnt_q     <= cnt_nx;
				if (row_wrap) begin
					col_step_q <= '0;
					row_step_q <= row_step_q + STEP_W'(1);
				end else begin
					col_step_q <= col_step_q + STEP_W'(1);
				end
			end
		end
	end

endmodule

// ===== hw/rtl/twc_queue.sv =====
// ----------------------------------------------------------------------------
// twc_queue: short job queue
// A small first-in first-out buffer of finished windows between the
// accumulator and the divider.
// ----------------------------------------------------------------------------
module twc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign empty = fill_q == '0;
	assign full  = fill_q == CNT_W'(DEPTH);
	assign head  = slot_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/twc_back.sv =====
// ----------------------------------------------------------------------------
// twc_back: centroid divider
// Takes window jobs from the queue, divides both sums by the bright count with
// a radix-2 restoring divider and holds the result word for the output port.
// ----------------------------------------------------------------------------
module twc_back #(
	parameter int COORD_BITS = 12,
	localparam int JOB_W = 1 + twc_pkg::CNT_W + 2 * twc_pkg::SUM_W + 2 * COORD_BITS,
	localparam int OUT_W = COORD_BITS + twc_pkg::FRAC_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  logic [JOB_W-1:0] job_data,
	output logic             job_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_found,
	output logic [OUT_W-1:0] out_x,
	output logic [OUT_W-1:0] out_y
);

	localparam int SUM_W  = twc_pkg::SUM_W;
	localparam int CNT_W  = twc_pkg::CNT_W;
	localparam int FRAC_W = twc_pkg::FRAC_W;
	localparam int DVD_W  = SUM_W + FRAC_W;
	localparam int ITER_W = $clog2(DVD_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] rem;
		logic [DVD_W-1:0] dvd;
	} div_t;

	state_t            state_q;
	logic [ITER_W-1:0] iter_q;
	logic [CNT_W-1:0]  divisor_q;
	div_t              div_x_q, div_y_q;
	logic              found_q;
	logic [OUT_W-1:0]  res_x_q, res_y_q;
	logic              out_valid_q, out_found_q;
	logic [OUT_W-1:0]  out_x_q, out_y_q;

	logic              job_ok;
	logic [CNT_W-1:0]  job_cnt;
	logic [SUM_W-1:0]  job_col_sum, job_row_sum;
	logic [COORD_BITS-1:0] job_cx, job_cy;
	div_t              div_x_nx, div_y_nx;
	logic              out_load;

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	function automatic div_t div_step(input div_t cur, input logic [CNT_W-1:0] divisor);
		div_t             nxt;
		logic [CNT_W:0]   trial;
		logic             fits;
		trial = {cur.rem, cur.dvd[DVD_W-1]};
		fits = trial >= {1'b0, divisor};
		nxt.rem = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
		nxt.dvd = {cur.dvd[DVD_W-2:0], fits};
		return nxt;
	endfunction

	// Quotient clipped to the output range.
	function automatic logic [OUT_W-1:0] saturate(input logic [DVD_W-1:0] quot);
		return ((quot >> OUT_W) != '0) ? '1 : quot[OUT_W-1:0];
	endfunction

	assign {job_ok, job_cnt, job_col_sum, job_row_sum, job_cx, job_cy} = job_data;

	always_comb begin
		div_x_nx = div_step(div_x_q, divisor_q);
		div_y_nx = div_step(div_y_q, divisor_q);
	end

	// A finished result moves to the output word once that word is free or leaving.
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

	// Sequencer, divider registers and output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			divisor_q   <= '0;
			div_x_q     <= '0;
			div_y_q     <= '0;
			found_q     <= 1'b0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						found_q   <= job_ok;
						divisor_q <= job_cnt;
						div_x_q   <= '{rem: '0, dvd: {job_col_sum, FRAC_W'(0)}};
						div_y_q   <= '{rem: '0, dvd: {job_row_sum, FRAC_W'(0)}};
						res_x_q   <= {job_cx, FRAC_W'(0)};
						res_y_q   <= {job_cy, FRAC_W'(0)};
						iter_q    <= ITER_W'(DVD_W - 1);
						state_q   <= job_ok ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					div_x_q <= div_x_nx;
					div_y_q <= div_y_nx;
					if (iter_q == '0) begin
						res_x_q <= saturate(div_x_nx.dvd);
						res_y_q <= saturate(div_y_nx.dvd);
						state_q <= ST_DONE;
					end else begin
						iter_q <= iter_q - ITER_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_found_q <= found_q;
						out_x_q     <= res_x_q;
						out_y_q     <= res_y_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/thresholded_window_centroid.sv =====
// Path: last pixel, job queue, divider states IDLE, DIV (skipped when no pixel is
//   bright or the window starts outside the image), DONE, then the output word.
// Throughput: one pixel per cycle; the 32-step divider takes one window at a time,
//   and a two-entry window queue stalls input only when it is full.
// Reset: arst_n clears the accumulators, the queue and the output, and loads the
//   register defaults (threshold 250, side 5, image 640 by 480).
// ----------------------------------------------------------------------------
// thresholded_window_centroid: centroid of bright pixels in a square window
// Accumulates bright pixel positions per window and divides them by the
// bright count to give the centroid in 8-bit fixed-point fraction.
// ----------------------------------------------------------------------------
module thresholded_window_centroid #(
	parameter int MAX_WINDOW = 63,
	parameter int COORD_BITS = 12,
	localparam int IN_TDATA_W  = ((twc_pkg::PIX_W + 2 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W       = COORD_BITS + twc_pkg::FRAC_W,
	localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [twc_pkg::INDEX_W-1:0] cfg_index,
	input  logic [twc_pkg::CFG_W-1:0]   cfg_data,
	// Pixel input: tdata = pixel, center_x, center_y (from bit 0 up).
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [IN_TDATA_W-1:0]       s_axis_tdata,
	input  logic                        s_axis_tlast,
	// Result output: tdata = centroid_x, centroid_y (from bit 0 up); tuser = found.
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                        m_axis_tuser
);

	localparam int PIX_W = twc_pkg::PIX_W;
	localparam int JOB_W = 1 + twc_pkg::CNT_W + 2 * twc_pkg::SUM_W + 2 * COORD_BITS;

	twc_pkg::cfg_t    cfg_q;
	logic             in_accept;
	logic             q_push, q_pop, q_empty, q_full;
	logic [JOB_W-1:0] q_in, q_head;
	logic [OUT_W-1:0] res_x, res_y;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_threshold <= twc_pkg::THRESHOLD_RST;
			cfg_q.window_size      <= twc_pkg::WINDOW_RST;
			cfg_q.image_width      <= twc_pkg::WIDTH_RST;
			cfg_q.image_height     <= twc_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (twc_pkg::reg_index_t'(cfg_index))
				twc_pkg::REG_BRIGHT_THRESHOLD: begin
					cfg_q.bright_threshold <= cfg_data[twc_pkg::PIX_W-1:0];
				end
				twc_pkg::REG_WINDOW_SIZE: begin
					cfg_q.window_size <= cfg_data[twc_pkg::STEP_W-1:0];
				end
				twc_pkg::REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[twc_pkg::DIM_W-1:0];
				end
				twc_pkg::REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data[twc_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input is held off while the job queue has no room.
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	twc_front #(
		.MAX_WINDOW (MAX_WINDOW),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_accept   (in_accept),
		.in_pixel    (s_axis_tdata[PIX_W-1:0]),
		.in_center_x (s_axis_tdata[PIX_W+COORD_BITS-1:PIX_W]),
		.in_center_y (s_axis_tdata[PIX_W+2*COORD_BITS-1:PIX_W+COORD_BITS]),
		.in_last     (s_axis_tlast),
		.job_push    (q_push),
		.job_data    (q_in)
	);

	twc_queue #(
		.WIDTH (JOB_W),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	twc_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job_data  (q_head),
		.job_pop   (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_found (m_axis_tuser),
		.out_x     (res_x),
		.out_y     (res_y)
	);

	assign m_axis_tdata = OUT_TDATA_W'({res_y, res_x});

`ifndef SYNTHESIS
	// A window is never closed into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("window job pushed into a full queue");

	// The divider only takes a job that is there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job taken from an empty queue");

	// A closed window is waiting in the queue on the next cycle.
	a_job_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s_axis_tlast) |=> !q_empty)
		else $error("closed window missing from the queue");
`endif

endmodule
